// ----- hw/rtl/dpsc_pkg.sv -----
// Shared types, constants and rounding helpers of the dual PID steering and speed controller.
package dpsc_pkg;

    localparam int GAIN_W    = 24;
    localparam int CFG_IDX_W = 3;

    // Shared divider geometry: two quotient bits per cycle
    localparam int DIV_NUM_W = 56;
    localparam int DIV_DEN_W = 21;
    localparam int DIV_STEPS = DIV_NUM_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam longint MICRO        = 1000000;
    localparam longint TWO_MICRO    = 2000000;
    localparam longint TD_MIN       = 1000;
    localparam longint CM_DIV       = 50;
    localparam longint HINT_LIM     = 838860800;
    localparam longint SINT_LIM     = 838860800;
    localparam longint Q15_MAX      = 32767;
    localparam longint YAW_TURN     = 46080;
    localparam longint YAW_HALF     = 23040;
    localparam longint SHARP_ERR    = 5760;
    localparam longint SHARP_SPEED  = 5120;
    localparam longint BRAKE_FLOOR  = 9830;
    localparam longint TGT_MIN      = 1280;
    localparam longint TGT_MAX      = 12800;
    localparam longint WANT_ABSENT  = 25;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_HEADING  = 3'd0,
        REG_KI_HEADING  = 3'd1,
        REG_KD_HEADING  = 3'd2,
        REG_KP_VELOCITY = 3'd3,
        REG_KI_VELOCITY = 3'd4,
        REG_KD_VELOCITY = 3'd5,
        REG_STEER_RATE  = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [GAIN_W-1:0] kp_heading;
        logic [GAIN_W-1:0] ki_heading;
        logic [GAIN_W-1:0] kd_heading;
        logic [GAIN_W-1:0] kp_velocity;
        logic [GAIN_W-1:0] ki_velocity;
        logic [GAIN_W-1:0] kd_velocity;
        logic [GAIN_W-1:0] steer_rate_limit;
    } gains_t;

    // Divide by 2^k, rounding to nearest with ties away from zero
    function automatic longint rnd_shift(input longint x, input int k);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (x < 0) ? 64'(-x) : 64'(x);
        q = (mag + (64'd1 << (k - 1))) >> k;
        return (x < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp64(input longint x, input longint lo, input longint hi);
        longint r;
        r = x;
        if (x < lo)
        begin
            r = lo;
        end
        else if (x > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/dpsc_regs.sv -----
// Configuration register file holding the loop gains and steering rate limit.
module dpsc_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [dpsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dpsc_pkg::GAIN_W-1:0]    cfg_data,
    output dpsc_pkg::gains_t               gains
);

    dpsc_pkg::gains_t gains_reg;

    assign gains = gains_reg;

    // Write the addressed register, drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg <= '{steer_rate_limit: 24'd65536, default: '0};
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dpsc_pkg::REG_KP_HEADING:  gains_reg.kp_heading       <= cfg_data;
                dpsc_pkg::REG_KI_HEADING:  gains_reg.ki_heading       <= cfg_data;
                dpsc_pkg::REG_KD_HEADING:  gains_reg.kd_heading       <= cfg_data;
                dpsc_pkg::REG_KP_VELOCITY: gains_reg.kp_velocity      <= cfg_data;
                dpsc_pkg::REG_KI_VELOCITY: gains_reg.ki_velocity      <= cfg_data;
                dpsc_pkg::REG_KD_VELOCITY: gains_reg.kd_velocity      <= cfg_data;
                dpsc_pkg::REG_STEER_RATE:  gains_reg.steer_rate_limit <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/dpsc_div.sv -----
// Iterative unsigned restoring divider, two quotient bits per cycle.
module dpsc_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [dpsc_pkg::DIV_NUM_W-1:0] num,
    input  logic [dpsc_pkg::DIV_DEN_W-1:0] den,
    output logic                           done,
    output logic [dpsc_pkg::DIV_NUM_W-1:0] quot
);

    logic [dpsc_pkg::DIV_DEN_W-1:0] rem_reg;
    logic [dpsc_pkg::DIV_DEN_W-1:0] den_reg;
    logic [dpsc_pkg::DIV_NUM_W-1:0] num_reg;
    logic [dpsc_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [dpsc_pkg::DIV_DEN_W-1:0] rem_next;
    logic [dpsc_pkg::DIV_NUM_W-1:0] num_next;
    logic [dpsc_pkg::DIV_DEN_W:0]   trial;
    logic                           last_step;

    assign done = done_reg;
    assign quot = num_reg;
    assign last_step = (cnt_reg == dpsc_pkg::DIV_CNT_W'(dpsc_pkg::DIV_STEPS - 1));

    // Two shift-compare-subtract steps; quotient bits enter at the bottom
    always_comb
    begin
        rem_next = rem_reg;
        num_next = num_reg;
        trial    = '0;
        for (int i = 0; i < 2; i++)
        begin
            trial    = {rem_next, num_next[dpsc_pkg::DIV_NUM_W-1]};
            num_next = {num_next[dpsc_pkg::DIV_NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next    = dpsc_pkg::DIV_DEN_W'(trial - {1'b0, den_reg});
                num_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[dpsc_pkg::DIV_DEN_W-1:0];
            end
        end
    end

    // Load on start, advance while busy, flag the last step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            den_reg  <= '0;
            num_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && busy_reg && last_step;
            if (start)
            begin
                rem_reg  <= '0;
                den_reg  <= den;
                num_reg  <= num;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                num_reg <= num_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/dual_pid_steer_speed_controller.sv -----
// Top level: sequencer, shared multiplier and loop state of the steering and speed PID pair.
//
// One request on the input channel carries one control tick: headings, speeds,
// fallback distance, tick length and a clear flag. One result request follows
// on the output channel with smoothed steering, throttle, brake and yaw error.
// An item is taken when in_valid is high and in_stall low; a result is taken
// when out_valid is high and out_stall low.
// Gains are to be written over the cfg channel (cfg_ready is always high) only
// while the block is idle; the block does not enforce this. Unknown register
// indexes are dropped. Each tick runs as a sequence of steps through one 25x32
// multiplier and one divider that retires two quotient bits per cycle (28 steps
// per division). A division step goes through multiply, divider load, divide and
// write-back, a gain product through multiply and write-back; the fallback target
// step divides only when no wanted speed is given. The next request is taken in
// the cycle after the result is loaded at the earliest.
// in_stall stays high from acceptance until the result is loaded into the
// output register; the next tick is accepted while that result still waits.
// A stalled receiver holds the finished result in the output register and
// the sequencer waits before overwriting it.
// Reset clears all loop state, loads the default gains and empties the output.
module dual_pid_steer_speed_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           clear_state,
    input  logic [19:0]                    tick_us,
    input  logic signed [15:0]             desired_heading,
    input  logic signed [15:0]             current_heading,
    input  logic [16:0]                    measured_speed,
    input  logic [16:0]                    wanted_speed,
    input  logic [23:0]                    target_distance_cm,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [15:0]             steer_cmd,
    output logic [14:0]                    throttle_cmd,
    output logic [14:0]                    brake_cmd,
    output logic signed [15:0]             heading_error,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dpsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dpsc_pkg::GAIN_W-1:0]    cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_DLOAD, S_DIV, S_WB, S_OUT} state_t;
    typedef enum logic [3:0] {
        OP_HI, OP_HD, OP_HKP, OP_HKD, OP_HKI, OP_LIM,
        OP_TGT, OP_SI, OP_SD, OP_SKP, OP_SKD, OP_SKI
    } op_t;

    dpsc_pkg::gains_t gains;

    state_t             state_reg;
    op_t                op_reg;
    logic [19:0]        tick_reg;
    logic [16:0]        meas_reg;
    logic [16:0]        want_reg;
    logic [23:0]        cm_reg;
    logic signed [15:0] err_reg;
    logic signed [31:0] hint_reg;
    logic signed [15:0] lasth_reg;
    logic signed [31:0] sint_reg;
    logic signed [17:0] lasts_reg;
    logic signed [15:0] smooth_reg;
    logic signed [17:0] serr_reg;
    logic signed [31:0] deriv_reg;
    logic signed [56:0] prod_reg;
    longint             acc_reg;
    longint             cmd_reg;
    logic               neg_reg;
    logic               out_valid_reg;
    logic signed [15:0] steer_reg;
    logic [14:0]        throttle_reg;
    logic [14:0]        brake_reg;
    logic signed [15:0] herr_reg;

    logic signed [16:0] yaw_diff;
    logic signed [15:0] err_next;
    logic signed [16:0] hdiff;
    logic signed [18:0] sdiff;
    logic [19:0]        td;
    logic signed [24:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [56:0] mul_p;
    logic               needs_div;
    logic               div_sh16;
    logic [dpsc_pkg::DIV_DEN_W-1:0] den_sel;
    logic [56:0]        pmag;
    logic [dpsc_pkg::DIV_NUM_W-1:0] div_num;
    logic               div_start;
    logic               div_done;
    logic [dpsc_pkg::DIV_NUM_W-1:0] div_quot;
    longint             q64;
    longint             prod64;
    longint             want64;
    longint             meas64;
    longint             step64;
    longint             sm64;
    longint             tgt64;
    longint             sc64;
    longint             thr64;
    longint             brk64;
    logic               want_given;
    logic               sharp;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign steer_cmd     = steer_reg;
    assign throttle_cmd  = throttle_reg;
    assign brake_cmd     = brake_reg;
    assign heading_error = herr_reg;

    dpsc_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .gains     (gains)
    );

    dpsc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den_sel),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Wrap the yaw error into (-half turn, half turn]
    always_comb
    begin
        yaw_diff = 17'(desired_heading) - 17'(current_heading);
        if (yaw_diff > 17'(dpsc_pkg::YAW_HALF))
        begin
            err_next = 16'(yaw_diff - 17'(dpsc_pkg::YAW_TURN));
        end
        else if (yaw_diff <= -17'(dpsc_pkg::YAW_HALF))
        begin
            err_next = 16'(yaw_diff + 17'(dpsc_pkg::YAW_TURN));
        end
        else
        begin
            err_next = 16'(yaw_diff);
        end
    end

    assign hdiff      = 17'(err_reg) - 17'(lasth_reg);
    assign sdiff      = 19'(serr_reg) - 19'(lasts_reg);
    assign td         = (tick_reg < 20'(dpsc_pkg::TD_MIN)) ? 20'(dpsc_pkg::TD_MIN) : tick_reg;
    assign want_given = (want_reg > 17'(dpsc_pkg::WANT_ABSENT));

    // Select multiplier operands and divisor for the current step
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        needs_div = 1'b0;
        div_sh16  = 1'b0;
        den_sel   = '0;
        unique case (op_reg)
            OP_HI:
            begin
                mul_a = {5'b0, tick_reg};  mul_b = 32'(err_reg);
                needs_div = 1'b1; div_sh16 = 1'b1;
                den_sel = dpsc_pkg::DIV_DEN_W'(dpsc_pkg::MICRO);
            end
            OP_HD:
            begin
                mul_a = 25'(dpsc_pkg::MICRO);  mul_b = 32'(hdiff);
                needs_div = 1'b1; den_sel = {1'b0, td};
            end
            OP_HKP: begin mul_a = {1'b0, gains.kp_heading}; mul_b = 32'(err_reg); end
            OP_HKD: begin mul_a = {1'b0, gains.kd_heading}; mul_b = deriv_reg; end
            OP_HKI: begin mul_a = {1'b0, gains.ki_heading}; mul_b = hint_reg; end
            OP_LIM:
            begin
                mul_a = {1'b0, gains.steer_rate_limit};  mul_b = {12'b0, tick_reg};
                needs_div = 1'b1;
                den_sel = dpsc_pkg::DIV_DEN_W'(dpsc_pkg::TWO_MICRO);
            end
            OP_TGT:
            begin
                mul_a = {1'b0, cm_reg};  mul_b = 32'sd256;
                needs_div = !want_given;
                den_sel = dpsc_pkg::DIV_DEN_W'(dpsc_pkg::CM_DIV);
            end
            OP_SI:
            begin
                mul_a = {5'b0, tick_reg};  mul_b = 32'(serr_reg);
                needs_div = 1'b1; div_sh16 = 1'b1;
                den_sel = dpsc_pkg::DIV_DEN_W'(dpsc_pkg::MICRO);
            end
            OP_SD:
            begin
                mul_a = 25'(dpsc_pkg::MICRO);  mul_b = 32'(sdiff);
                needs_div = 1'b1; den_sel = {1'b0, td};
            end
            OP_SKP: begin mul_a = {1'b0, gains.kp_velocity}; mul_b = 32'(serr_reg); end
            OP_SKD: begin mul_a = {1'b0, gains.kd_velocity}; mul_b = deriv_reg; end
            OP_SKI: begin mul_a = {1'b0, gains.ki_velocity}; mul_b = sint_reg; end
            default:
            begin
            end
        endcase
    end

    assign mul_p = 57'(mul_a) * 57'(mul_b);

    // Rounded division: magnitude plus half the divisor
    assign pmag      = prod_reg[56] ? 57'(-prod_reg) : 57'(prod_reg);
    assign div_num   = (div_sh16 ? {pmag[39:0], 16'b0} : pmag[55:0])
                     + {36'b0, den_sel[dpsc_pkg::DIV_DEN_W-1:1]};
    assign div_start = (state_reg == S_DLOAD);
    assign q64       = neg_reg ? -longint'({8'b0, div_quot}) : longint'({8'b0, div_quot});
    assign prod64    = longint'(prod_reg);
    assign want64    = longint'({47'b0, want_reg});
    assign meas64    = longint'({47'b0, meas_reg});

    // Rate-limited steering, fallback target, pedal split and sharp-turn brake floor
    always_comb
    begin
        step64 = dpsc_pkg::clamp64(cmd_reg - longint'(smooth_reg), -q64, q64);
        sm64   = dpsc_pkg::clamp64(longint'(smooth_reg) + step64,
                                   -dpsc_pkg::Q15_MAX, dpsc_pkg::Q15_MAX);
        tgt64  = want_given ? want64
               : dpsc_pkg::clamp64(q64, dpsc_pkg::TGT_MIN, dpsc_pkg::TGT_MAX);
        sc64   = cmd_reg;
        if (sc64 > 0)
        begin
            thr64 = (sc64 > dpsc_pkg::Q15_MAX) ? dpsc_pkg::Q15_MAX : sc64;
            brk64 = 0;
        end
        else
        begin
            thr64 = 0;
            brk64 = dpsc_pkg::rnd_shift(-sc64, 1);
            if (brk64 > dpsc_pkg::Q15_MAX)
            begin
                brk64 = dpsc_pkg::Q15_MAX;
            end
        end
        sharp = ((err_reg > 16'(dpsc_pkg::SHARP_ERR)) || (err_reg < -16'(dpsc_pkg::SHARP_ERR)))
              && (meas_reg > 17'(dpsc_pkg::SHARP_SPEED));
        if (sharp)
        begin
            thr64 = 0;
            if (brk64 < dpsc_pkg::BRAKE_FLOOR)
            begin
                brk64 = dpsc_pkg::BRAKE_FLOOR;
            end
        end
    end

    // Sequencer: accept, step through the operations, hand off the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_HI;
            tick_reg      <= '0;
            meas_reg      <= '0;
            want_reg      <= '0;
            cm_reg        <= '0;
            err_reg       <= '0;
            hint_reg      <= '0;
            lasth_reg     <= '0;
            sint_reg      <= '0;
            lasts_reg     <= '0;
            smooth_reg    <= '0;
            serr_reg      <= '0;
            deriv_reg     <= '0;
            prod_reg      <= '0;
            acc_reg       <= '0;
            cmd_reg       <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            steer_reg     <= '0;
            throttle_reg  <= '0;
            brake_reg     <= '0;
            herr_reg      <= '0;
        end
        else
        begin
            // Drop the taken result unless a new one is loaded this cycle
            if (out_valid_reg && !out_stall && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        tick_reg  <= tick_us;
                        meas_reg  <= measured_speed;
                        want_reg  <= wanted_speed;
                        cm_reg    <= target_distance_cm;
                        err_reg   <= err_next;
                        op_reg    <= OP_HI;
                        state_reg <= S_MUL;
                        if (clear_state)
                        begin
                            hint_reg   <= '0;
                            lasth_reg  <= '0;
                            sint_reg   <= '0;
                            lasts_reg  <= '0;
                            smooth_reg <= '0;
                        end
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= needs_div ? S_DLOAD : S_WB;
                end
                S_DLOAD:
                begin
                    neg_reg   <= prod_reg[56];
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_WB;
                    end
                end
                S_WB:
                begin
                    op_reg    <= op_t'(op_reg + 4'd1);
                    state_reg <= (op_reg >= OP_SKI) ? S_OUT : S_MUL;
                    unique case (op_reg)
                        OP_HI:
                            hint_reg <= 32'(dpsc_pkg::clamp64(longint'(hint_reg) + q64,
                                            -dpsc_pkg::HINT_LIM, dpsc_pkg::HINT_LIM));
                        OP_HD:
                        begin
                            deriv_reg <= 32'(q64);
                            lasth_reg <= err_reg;
                        end
                        OP_HKP: acc_reg <= prod64;
                        OP_HKD: cmd_reg <= dpsc_pkg::rnd_shift(acc_reg + prod64, 8);
                        OP_HKI:
                            cmd_reg <= dpsc_pkg::clamp64(
                                cmd_reg + dpsc_pkg::rnd_shift(prod64, 24),
                                -dpsc_pkg::Q15_MAX, dpsc_pkg::Q15_MAX);
                        OP_LIM: smooth_reg <= 16'(sm64);
                        OP_TGT: serr_reg <= 18'(tgt64 - meas64);
                        OP_SI:
                            sint_reg <= 32'(dpsc_pkg::clamp64(longint'(sint_reg) + q64,
                                            -dpsc_pkg::SINT_LIM, dpsc_pkg::SINT_LIM));
                        OP_SD:
                        begin
                            deriv_reg <= 32'(q64);
                            lasts_reg <= serr_reg;
                        end
                        OP_SKP: acc_reg <= prod64;
                        OP_SKD: cmd_reg <= dpsc_pkg::rnd_shift(acc_reg + prod64, 9);
                        OP_SKI: cmd_reg <= cmd_reg + dpsc_pkg::rnd_shift(prod64, 25);
                        default:
                        begin
                        end
                    endcase
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        steer_reg     <= smooth_reg;
                        throttle_reg  <= 15'(thr64);
                        brake_reg     <= 15'(brk64);
                        herr_reg      <= err_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Smoothed steering never leaves the Q1.15 range
    a_smooth_range: assert property (@(posedge clk) disable iff (!rst_n)
        (smooth_reg >= -16'sd32767))
        else $error("smoothed steering out of range");

    // Heading integral stays inside its anti-windup clamp
    a_hint_range: assert property (@(posedge clk) disable iff (!rst_n)
        (hint_reg <= 32'sd838860800) && (hint_reg >= -32'sd838860800))
        else $error("heading integral beyond clamp");

    // Divider completes only while the sequencer waits for it
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside a division step");

    // Throttle and brake are never both applied
    a_pedals: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((throttle_reg == 15'd0) || (brake_reg == 15'd0)))
        else $error("throttle and brake both nonzero");

    // A new result is loaded only into a free or draining output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && state_reg == S_OUT) |=> (state_reg == S_OUT))
        else $error("result overwritten while stalled");

endmodule

// ----- sim/dual_pid_steer_speed_controller_tb.sv -----
// Dual PID steering and speed controller testbench: directed and random ticks vs a local predictor.
module dual_pid_steer_speed_controller_tb;

    typedef struct {
        logic        clr;
        logic [19:0] tick;
        logic [15:0] des;
        logic [15:0] cur;
        logic [16:0] meas;
        logic [16:0] want;
        logic [23:0] dist_cm;
    } tick_req_t;

    typedef struct {
        logic [15:0] steer;
        logic [14:0] throttle;
        logic [14:0] brake;
        logic [15:0] yaw_err;
    } pedal_cmd_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic clear_state;
    logic [19:0] tick_us;
    logic signed [15:0] desired_heading;
    logic signed [15:0] current_heading;
    logic [16:0] measured_speed;
    logic [16:0] wanted_speed;
    logic [23:0] target_distance_cm;
    logic out_valid;
    logic out_stall;
    logic signed [15:0] steer_cmd;
    logic [14:0] throttle_cmd;
    logic [14:0] brake_cmd;
    logic signed [15:0] heading_error;
    logic cfg_valid;
    logic cfg_ready;
    logic [dpsc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dpsc_pkg::GAIN_W-1:0] cfg_data;

    dual_pid_steer_speed_controller dut (.*);

    // Predictor copy of gains and loop state
    longint g_kph, g_kih, g_kdh, g_kpv, g_kiv, g_kdv, g_rate;
    longint p_hint, p_lherr, p_sint, p_lserr, p_steer;

    tick_req_t  tick_queue[$];
    pedal_cmd_t cmd_queue[$];
    int mismatches;
    int n_sent;
    int n_taken;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic longint div_round(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint limit(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Advance predicted state by one tick and return the expected command
    function automatic pedal_cmd_t predict_pedals(input tick_req_t r);
        longint t, td, err, deriv, cmd, lim, target, serr, sc, thr, brk;
        pedal_cmd_t o;
        t = r.tick;
        td = (t < 1000) ? 1000 : t;
        if (r.clr)
        begin
            p_hint = 0;
            p_lherr = 0;
            p_sint = 0;
            p_lserr = 0;
            p_steer = 0;
        end
        err = (longint'($signed(r.des)) - longint'($signed(r.cur))) % 46080;
        if (err < 0)
            err += 46080;
        if (err > 23040)
            err -= 46080;
        p_hint = limit(p_hint + div_round(err * t * 65536, 1000000),
                       -dpsc_pkg::HINT_LIM, dpsc_pkg::HINT_LIM);
        deriv = div_round((err - p_lherr) * 1000000, td);
        p_lherr = err;
        cmd = div_round(g_kph * err + g_kdh * deriv, 256) + div_round(g_kih * p_hint, 1 << 24);
        cmd = limit(cmd, -dpsc_pkg::Q15_MAX, dpsc_pkg::Q15_MAX);
        lim = div_round(g_rate * t, 2000000);
        p_steer = limit(p_steer + limit(cmd - p_steer, -lim, lim),
                        -dpsc_pkg::Q15_MAX, dpsc_pkg::Q15_MAX);
        if (r.want > 25)
            target = r.want;
        else
            target = limit(div_round(longint'(r.dist_cm) * 256, 50), 1280, 12800);
        serr = target - longint'(r.meas);
        p_sint = limit(p_sint + div_round(serr * t * 65536, 1000000),
                       -dpsc_pkg::SINT_LIM, dpsc_pkg::SINT_LIM);
        deriv = div_round((serr - p_lserr) * 1000000, td);
        p_lserr = serr;
        sc = div_round(g_kpv * serr + g_kdv * deriv, 512) + div_round(g_kiv * p_sint, 1 << 25);
        if (sc > 0)
        begin
            thr = (sc > dpsc_pkg::Q15_MAX) ? dpsc_pkg::Q15_MAX : sc;
            brk = 0;
        end
        else
        begin
            thr = 0;
            brk = div_round(-sc, 2);
            if (brk > dpsc_pkg::Q15_MAX)
                brk = dpsc_pkg::Q15_MAX;
        end
        // Sharp turn at speed: force brake floor and cut throttle
        if ((err > 5760 || err < -5760) && r.meas > 5120)
        begin
            if (brk < 9830)
                brk = 9830;
            thr = 0;
        end
        o.steer = p_steer[15:0];
        o.throttle = thr[14:0];
        o.brake = brk[14:0];
        o.yaw_err = err[15:0];
        return o;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40)
            return 0;
        else if (k < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Sample input acceptance at the rising edge and predict
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            cmd_queue.push_back(predict_pedals(tick_queue.pop_front()));
            n_taken++;
        end
    end

    // Driver: hold a pending request, then idle or present the next one
    int drv_gap;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && n_taken == n_sent)
            begin
                drv_gap = gap_len();
            end
            if (in_valid && n_taken != n_sent)
            begin
                // hold the pending request
            end
            else if (drv_gap > 0)
            begin
                drv_gap--;
                in_valid <= 1'b0;
            end
            else if (tick_queue.size() > 0)
            begin
                in_valid <= 1'b1;
                clear_state <= tick_queue[0].clr;
                tick_us <= tick_queue[0].tick;
                desired_heading <= tick_queue[0].des;
                current_heading <= tick_queue[0].cur;
                measured_speed <= tick_queue[0].meas;
                wanted_speed <= tick_queue[0].want;
                target_distance_cm <= tick_queue[0].dist_cm;
                n_sent++;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random gaps, mostly short
    int stall_cnt;
    always @(negedge clk)
    begin
        if (stall_cnt > 0)
        begin
            stall_cnt--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_cnt = gap_len();
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        pedal_cmd_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (cmd_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result steer=%0d", steer_cmd);
            end
            else
            begin
                e = cmd_queue.pop_front();
                if (e.steer !== steer_cmd || e.throttle !== throttle_cmd ||
                    e.brake !== brake_cmd || e.yaw_err !== heading_error)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp s=%0d t=%0d b=%0d e=%0d got s=%0d t=%0d b=%0d e=%0d",
                                 $signed(e.steer), e.throttle, e.brake, $signed(e.yaw_err),
                                 steer_cmd, throttle_cmd, brake_cmd, heading_error);
                end
            end
        end
    end

    task automatic write_reg(input dpsc_pkg::reg_index_t idx, input longint val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[dpsc_pkg::GAIN_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            dpsc_pkg::REG_KP_HEADING:  g_kph = val;
            dpsc_pkg::REG_KI_HEADING:  g_kih = val;
            dpsc_pkg::REG_KD_HEADING:  g_kdh = val;
            dpsc_pkg::REG_KP_VELOCITY: g_kpv = val;
            dpsc_pkg::REG_KI_VELOCITY: g_kiv = val;
            dpsc_pkg::REG_KD_VELOCITY: g_kdv = val;
            dpsc_pkg::REG_STEER_RATE:  g_rate = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Write an index past the register list; it must be dropped
    task automatic write_bad_index();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= 3'd7;
        cfg_data <= 24'($urandom());
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (tick_queue.size() > 0 || cmd_queue.size() > 0 || in_valid)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic longint pick_gain(input int mode);
        case (mode)
            0: return 0;
            1: return 24'hFFFFFF;
            default: return $urandom_range(0, 4 * 65536);
        endcase
    endfunction

    task automatic load_gains(input int mode);
        write_reg(dpsc_pkg::REG_KP_HEADING, pick_gain(mode));
        write_reg(dpsc_pkg::REG_KI_HEADING, pick_gain(mode));
        write_reg(dpsc_pkg::REG_KD_HEADING, pick_gain(mode));
        write_reg(dpsc_pkg::REG_KP_VELOCITY, pick_gain(mode));
        write_reg(dpsc_pkg::REG_KI_VELOCITY, pick_gain(mode));
        write_reg(dpsc_pkg::REG_KD_VELOCITY, pick_gain(mode));
        write_reg(dpsc_pkg::REG_STEER_RATE,
                  (mode == 2) ? $urandom_range(0, 8 * 65536) : pick_gain(mode));
    endtask

    function automatic tick_req_t rand_tick();
        tick_req_t r;
        int k;
        r.clr = ($urandom_range(0, 19) == 0);
        k = $urandom_range(0, 9);
        r.tick = (k == 0) ? 20'd0 : (k == 1) ? 20'($urandom())
                 : (k < 4) ? 20'($urandom_range(0, 2000)) : 20'($urandom_range(1000, 100000));
        k = $urandom_range(0, 9);
        r.des = (k == 0) ? 16'($urandom()) : 16'($signed($urandom_range(0, 46080)) - 23040);
        r.cur = (k == 1) ? 16'($urandom()) : 16'($signed($urandom_range(0, 46080)) - 23040);
        r.meas = ($urandom_range(0, 9) == 0) ? 17'($urandom()) : 17'($urandom_range(0, 76800));
        k = $urandom_range(0, 9);
        r.want = (k < 3) ? 17'($urandom_range(0, 25)) : (k == 3) ? 17'($urandom())
                 : 17'($urandom_range(26, 76800));
        r.dist_cm = ($urandom_range(0, 3) == 0) ? 24'($urandom())
                    : 24'($urandom_range(0, 5000));
        return r;
    endfunction

    function automatic tick_req_t make_tick(input longint c, input longint t, input longint d,
                                            input longint cu, input longint m, input longint w,
                                            input longint cm);
        tick_req_t r;
        r.clr = (c != 0);
        r.tick = t[19:0];
        r.des = d[15:0];
        r.cur = cu[15:0];
        r.meas = m[16:0];
        r.want = w[16:0];
        r.dist_cm = cm[23:0];
        return r;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        clear_state = 1'b0;
        tick_us = '0;
        desired_heading = '0;
        current_heading = '0;
        measured_speed = '0;
        wanted_speed = '0;
        target_distance_cm = '0;
        drv_gap = 0;
        stall_cnt = 0;
        mismatches = 0;
        n_sent = 0;
        n_taken = 0;
        g_kph = 0; g_kih = 0; g_kdh = 0; g_kpv = 0; g_kiv = 0; g_kdv = 0; g_rate = 65536;
        p_hint = 0; p_lherr = 0; p_sint = 0; p_lserr = 0; p_steer = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset gains, then extremes and special cases
        tick_queue.push_back(make_tick(0, 10000, 100, -100, 1000, 2560, 0));
        drain();
        load_gains(2);
        write_bad_index();
        tick_queue.push_back(make_tick(1, 0, 23040, -23040, 0, 0, 0));
        tick_queue.push_back(make_tick(0, 0, -23040, 23040, 76800, 76800, 16777215));
        tick_queue.push_back(make_tick(0, 1000000, 32767, -32768, 0, 25, 16777215));
        tick_queue.push_back(make_tick(0, 20'hFFFFF, -32768, 32767, 131071, 131071, 0));
        tick_queue.push_back(make_tick(0, 999, 8000, 0, 6000, 26, 100));
        tick_queue.push_back(make_tick(0, 1000, -8000, 0, 5121, 0, 1000));
        tick_queue.push_back(make_tick(0, 20000, 5761, 0, 5120, 0, 50));
        tick_queue.push_back(make_tick(1, 20000, 0, 5761, 5121, 12800, 0));
        tick_queue.push_back(make_tick(0, 500, 0, 0, 0, 0, 24'hAAAAAA));
        drain();
        load_gains(1);
        for (int i = 0; i < 8; i++)
            tick_queue.push_back(rand_tick());
        drain();
        load_gains(0);
        for (int i = 0; i < 4; i++)
            tick_queue.push_back(rand_tick());
        drain();

        // Random phases with varying gains
        for (int ph = 0; ph < 6; ph++)
        begin
            load_gains((ph == 3) ? 1 : 2);
            for (int i = 0; i < 105; i++)
                tick_queue.push_back(rand_tick());
            drain();
        end

        if (mismatches == 0 && cmd_queue.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
